// File: rtl/crc10_pkg.sv
// Shared constants, register indexes and bit-step helpers for the CRC-10 unit.
package crc10_pkg;

  localparam int unsigned CRC_W  = 10;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FLUSH_HALF = CRC_W / 2;

  typedef logic [CRC_W-1:0] crc_t;

  typedef enum logic [1:0] {
    REG_GENERATOR_POLY = 2'd0,
    REG_INITIAL_VALUE  = 2'd1,
    REG_LSB_FIRST      = 2'd2,
    REG_REFLECT_CRC    = 2'd3
  } cfg_reg_t;

  localparam crc_t POLY_RESET = crc_t'(563);
  localparam crc_t INIT_RESET = crc_t'(0);

  // One augmented shift: bit in at the bottom, XOR poly when bit 9 falls out.
  function automatic crc_t shift_bit(crc_t r, logic b, crc_t poly);
    crc_t s;
    s = {r[CRC_W-2:0], b};
    if (r[CRC_W-1]) begin
      s = s ^ poly;
    end
    return s;
  endfunction

  function automatic crc_t reverse_crc(crc_t v);
    crc_t r;
    for (int i = 0; i < CRC_W; i++) begin
      r[i] = v[CRC_W-1-i];
    end
    return r;
  endfunction

  function automatic crc_t shift_byte(crc_t r, logic [BYTE_W-1:0] d, logic lsb, crc_t poly);
    crc_t s;
    s = r;
    for (int i = 0; i < BYTE_W; i++) begin
      s = shift_bit(s, lsb ? d[i] : d[BYTE_W-1-i], poly);
    end
    return s;
  endfunction

  // Half of the ten-zero flush.
  function automatic crc_t flush_half(crc_t r, crc_t poly);
    crc_t s;
    s = r;
    for (int i = 0; i < FLUSH_HALF; i++) begin
      s = shift_bit(s, 1'b0, poly);
    end
    return s;
  endfunction

endpackage

// File: rtl/crc10_augmented_configurable.sv
// Top level of the configurable augmented CRC-10 unit.
// Takes one message byte per cycle while in_ready is high. The byte enters an input
// register; from there the eight bit shifts run against the running CRC register,
// which is the only feedback loop, so a byte can follow in every cycle unless a last
// byte waits for the flush. A last byte then passes through two flush stages of five
// zero shifts each and the output register, where its CRC is offered. A stalled
// result holds in the output register while the stages behind it keep filling.
// The polynomial, seed, bit order and reflection are written through the plain
// write port; the user must write them while the unit is idle, as the block does not enforce it.
module crc10_augmented_configurable (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_addr,
  input  logic [crc10_pkg::CRC_W-1:0] cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               data_byte,
  input  logic                     last_byte,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [9:0]               crc_value
);

  crc10_pkg::crc_t generator_poly;
  crc10_pkg::crc_t initial_value;
  logic            lsb_first;
  logic            reflect_crc;

  crc10_pkg::crc_t crc_register;
  crc10_pkg::crc_t crc_register_next;
  logic            in_message;

  logic [7:0]      s1_data;
  logic            s1_last;
  logic            s1_valid;
  crc10_pkg::crc_t s2_crc;
  logic            s2_valid;
  crc10_pkg::crc_t s3_crc;
  logic            s3_valid;
  crc10_pkg::crc_t out_crc;

  logic out_free, s3_free, s2_free, s1_fire, s1_free;
  crc10_pkg::crc_t seed;

  assign out_free = !out_valid || out_ready;
  assign s3_free  = !s3_valid || out_free;
  assign s2_free  = !s2_valid || s3_free;
  assign s1_fire  = s1_valid && (!s1_last || s2_free);
  assign s1_free  = !s1_valid || s1_fire;
  assign in_ready = s1_free;

  assign seed = reflect_crc ? crc10_pkg::reverse_crc(initial_value) : initial_value;

  always_comb begin
    crc_register_next = crc10_pkg::shift_byte(in_message ? crc_register : seed,
                                              s1_data, lsb_first, generator_poly);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      generator_poly <= crc10_pkg::POLY_RESET;
      initial_value  <= crc10_pkg::INIT_RESET;
      lsb_first      <= 1'b0;
      reflect_crc    <= 1'b0;
    end else if (cfg_we) begin
      unique case (crc10_pkg::cfg_reg_t'(cfg_addr))
        crc10_pkg::REG_GENERATOR_POLY: generator_poly <= cfg_wdata;
        crc10_pkg::REG_INITIAL_VALUE:  initial_value  <= cfg_wdata;
        crc10_pkg::REG_LSB_FIRST:      lsb_first      <= cfg_wdata[0];
        crc10_pkg::REG_REFLECT_CRC:    reflect_crc    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      out_valid    <= 1'b0;
      in_message   <= 1'b0;
      crc_register <= '0;
    end else begin
      // input register
      if (s1_free) begin
        s1_valid <= in_valid;
      end
      // byte step; a last byte closes the message and moves on to the flush
      if (s1_fire) begin
        crc_register <= crc_register_next;
        in_message   <= !s1_last;
      end
      if (s2_free) begin
        s2_valid <= s1_fire && s1_last;
      end
      if (s3_free) begin
        s3_valid <= s2_valid;
      end
      if (out_free) begin
        out_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_valid) begin
      s1_data <= data_byte;
      s1_last <= last_byte;
    end
    if (s2_free && s1_fire && s1_last) begin
      s2_crc <= crc_register_next;
    end
    if (s3_free && s2_valid) begin
      s3_crc <= crc10_pkg::flush_half(s2_crc, generator_poly);
    end
    if (out_free && s3_valid) begin
      out_crc <= reflect_crc
                 ? crc10_pkg::reverse_crc(crc10_pkg::flush_half(s3_crc, generator_poly))
                 : crc10_pkg::flush_half(s3_crc, generator_poly);
    end
  end

  assign crc_value = out_crc;

endmodule
